@@ rtl/nms_pkg.sv @@
// ----------------------------------------------------------------------------
// nms_pkg
// Shared types, constants and the neighbour-mean arithmetic for the
// neighbour mean smoothing core.
// ----------------------------------------------------------------------------
package nms_pkg;

    // Frame geometry
    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = 12;
    localparam int ROWS_CFG_W  = 13;
    localparam int COLS_CFG_W  = 11;
    localparam int MAX_ROWS    = 4096;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 8'd1;

    // Output queue
    localparam int OUTQ_DEPTH = 16;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;
    localparam int MAX_RESULTS = 4;
    // one item in flight plus the one being taken may each push MAX_RESULTS
    localparam logic [OUTQ_CNT_W-1:0] OUTQ_READY_LIMIT =
        OUTQ_CNT_W'(OUTQ_DEPTH - 2 * MAX_RESULTS);

    // Reciprocals for floor(sum * 256 / d): (sum * ceil(2^21 / d)) >> 13
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 13;
    localparam logic [RECIP_W-1:0] RECIP_3 = 20'd699051;
    localparam logic [RECIP_W-1:0] RECIP_5 = 20'd419431;

    localparam int SUM_W    = 11;
    localparam int RESULT_W = 16;

    typedef logic [7:0] pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    typedef struct packed {
        column_t left;
        column_t centre;
        column_t right;
    } window_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    column;
        logic [RESULT_W-1:0] smoothed;
        logic                last;
    } result_t;

    // Mean of the in-bounds 8-neighbours of the window centre, Q8.8, floor.
    function automatic logic [RESULT_W-1:0] neighbour_mean(
        window_t w,
        logic    top_ok,
        logic    bot_ok,
        logic    left_ok,
        logic    right_ok
    );
        logic [SUM_W-1:0]             sum;
        logic [RECIP_W-1:0]           recip;
        logic [SUM_W+RECIP_W-1:0]     prod;
        logic [RESULT_W-1:0]          res;
        sum = '0;
        if (top_ok && left_ok)  sum = sum + SUM_W'(w.left.top);
        if (top_ok)             sum = sum + SUM_W'(w.centre.top);
        if (top_ok && right_ok) sum = sum + SUM_W'(w.right.top);
        if (left_ok)            sum = sum + SUM_W'(w.left.mid);
        if (right_ok)           sum = sum + SUM_W'(w.right.mid);
        if (bot_ok && left_ok)  sum = sum + SUM_W'(w.left.bot);
        if (bot_ok)             sum = sum + SUM_W'(w.centre.bot);
        if (bot_ok && right_ok) sum = sum + SUM_W'(w.right.bot);
        if (top_ok && bot_ok && left_ok && right_ok) begin
            // interior: divide by 8
            res   = {sum, 5'b0};
            recip = '0;
            prod  = '0;
        end else begin
            // edge: 5 neighbours, corner: 3
            recip = ((top_ok && bot_ok) || (left_ok && right_ok)) ? RECIP_5 : RECIP_3;
            prod  = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(recip);
            res   = prod[RECIP_SHIFT +: RESULT_W];
        end
        return res;
    endfunction

endpackage

@@ rtl/neighbour_mean_smoothing_core.sv @@
// ----------------------------------------------------------------------------
// neighbour_mean_smoothing_core
// Raster-order 3x3 neighbour mean (centre excluded) with a two-row line store,
// a sliding window and a small output queue.
// ----------------------------------------------------------------------------
// Path: a sample word is taken with its line store read, then the stage-1
//   window/divide pushes its results into the output queue feeding the m_ ports.
// Throughput: one sample word per cycle while s_ready, one result word per
//   cycle out while m_ready. The last row yields two results per sample and
//   the final one four, so the 16-deep output queue drops s_ready above 8 queued.
// Reset: counters, queue and geometry registers are cleared (2 x 2 frame);
//   the line store is not cleared and needs no clearing pass.
module neighbour_mean_smoothing_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nms_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [nms_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sample input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_sample,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [nms_pkg::ROW_W-1:0]            m_out_row,
    output logic [nms_pkg::COL_W-1:0]            m_out_column,
    output logic [nms_pkg::RESULT_W-1:0]         m_smoothed,
    output logic                                 m_last_of_run
);

    localparam int ROW_W = nms_pkg::ROW_W;
    localparam int COL_W = nms_pkg::COL_W;
    localparam int PTR_W = nms_pkg::OUTQ_PTR_W;
    localparam int CNT_W = nms_pkg::OUTQ_CNT_W;
    localparam int NRES  = nms_pkg::MAX_RESULTS;

    // ------------------------------------------------------------------
    // Geometry registers: kept as last row / last column index, clamped
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [nms_pkg::ROWS_CFG_W-1:0] rows_raw, rows_eff;
    logic [nms_pkg::COLS_CFG_W-1:0] cols_raw, cols_eff;
    logic cfg_write, cfg_known;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == nms_pkg::REG_ROW_COUNT) ||
                       (cfg_index == nms_pkg::REG_COLUMN_COUNT);

    always_comb begin
        rows_raw = cfg_data[nms_pkg::ROWS_CFG_W-1:0];
        cols_raw = cfg_data[nms_pkg::COLS_CFG_W-1:0];
        if (rows_raw < nms_pkg::ROWS_CFG_W'(2))
            rows_eff = nms_pkg::ROWS_CFG_W'(2);
        else if (rows_raw > nms_pkg::ROWS_CFG_W'(nms_pkg::MAX_ROWS))
            rows_eff = nms_pkg::ROWS_CFG_W'(nms_pkg::MAX_ROWS);
        else
            rows_eff = rows_raw;
        if (cols_raw < nms_pkg::COLS_CFG_W'(2))
            cols_eff = nms_pkg::COLS_CFG_W'(2);
        else if (cols_raw > nms_pkg::COLS_CFG_W'(nms_pkg::MAX_COLUMNS))
            cols_eff = nms_pkg::COLS_CFG_W'(nms_pkg::MAX_COLUMNS);
        else
            cols_eff = cols_raw;
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        if (cfg_write) begin
            case (cfg_index)
                nms_pkg::REG_ROW_COUNT: begin
                    last_row_next = ROW_W'(rows_eff - nms_pkg::ROWS_CFG_W'(1));
                end
                nms_pkg::REG_COLUMN_COUNT: begin
                    last_col_next = COL_W'(cols_eff - nms_pkg::COLS_CFG_W'(1));
                end
                default: begin
                    // unlisted index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_row_reg <= ROW_W'(1);
            last_col_reg <= COL_W'(1);
        end else begin
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
        end
    end

    // ------------------------------------------------------------------
    // Input side: raster position counters and line store read
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_position_reg, row_position_next;
    logic [COL_W-1:0] column_position_reg, column_position_next;
    logic [CNT_W-1:0] outq_count_reg, outq_count_next;
    logic in_accept;

    assign s_ready   = (outq_count_reg <= nms_pkg::OUTQ_READY_LIMIT);
    assign in_accept = s_valid && s_ready;

    always_comb begin
        row_position_next    = row_position_reg;
        column_position_next = column_position_reg;
        if (cfg_write && cfg_known) begin
            // any listed register write restarts the frame
            row_position_next    = '0;
            column_position_next = '0;
        end else if (in_accept) begin
            if (column_position_reg == last_col_reg) begin
                column_position_next = '0;
                row_position_next    = (row_position_reg == last_row_reg) ? '0
                                       : row_position_reg + ROW_W'(1);
            end else begin
                column_position_next = column_position_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_position_reg    <= '0;
            column_position_reg <= '0;
        end else begin
            row_position_reg    <= row_position_next;
            column_position_reg <= column_position_next;
        end
    end

    // Line store: per column {row r-1, row r-2}, read as the word is taken,
    // written back in the next cycle. Consecutive words hit different columns.
    logic [15:0] line_mem [nms_pkg::MAX_COLUMNS];
    logic [15:0] line_rd_reg;

    logic             s1_valid_reg;
    nms_pkg::pix_t    s1_sample_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            line_rd_reg <= line_mem[column_position_reg];
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= {s1_sample_reg, line_rd_reg[15:8]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_sample_reg <= s_sample;
            s1_row_reg    <= row_position_reg;
            s1_col_reg    <= column_position_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window, neighbour means, queue push
    // ------------------------------------------------------------------
    nms_pkg::column_t win_l_reg, win_m_reg;   // columns c-2 and c-1
    nms_pkg::column_t col_new;                // column c
    nms_pkg::column_t col_zero;
    nms_pkg::column_t up_l, up_m, up_n;       // rows r-1, r shifted to top/mid
    nms_pkg::window_t win0, win1, win2, win3;
    logic r_ge1, r_ge2, c_ge1, c_ge2, at_last_row, at_last_col;
    logic [NRES-1:0]  emit;
    logic [NRES-1:0]  is_last;
    nms_pkg::result_t item [NRES];
    logic [PTR_W-1:0] wr_addr [NRES];
    logic [2:0]       rank [NRES];
    logic [2:0]       push_count;

    always_comb begin
        col_new  = '{top: line_rd_reg[7:0], mid: line_rd_reg[15:8], bot: s1_sample_reg};
        col_zero = '0;
        up_l = '{top: win_l_reg.mid, mid: win_l_reg.bot, bot: 8'd0};
        up_m = '{top: win_m_reg.mid, mid: win_m_reg.bot, bot: 8'd0};
        up_n = '{top: col_new.mid,   mid: col_new.bot,   bot: 8'd0};

        // window centred on each candidate cell
        win0 = '{left: win_l_reg, centre: win_m_reg, right: col_new};  // (r-1, c-1)
        win1 = '{left: win_m_reg, centre: col_new,   right: col_zero}; // (r-1, c)
        win2 = '{left: up_l,      centre: up_m,      right: up_n};     // (r, c-1)
        win3 = '{left: up_m,      centre: up_n,      right: col_zero}; // (r, c)

        r_ge1       = (s1_row_reg != '0);
        r_ge2       = (s1_row_reg[ROW_W-1:1] != '0);
        c_ge1       = (s1_col_reg != '0);
        c_ge2       = (s1_col_reg[COL_W-1:1] != '0);
        at_last_row = (s1_row_reg == last_row_reg);
        at_last_col = (s1_col_reg == last_col_reg);

        emit[0] = s1_valid_reg && r_ge1 && c_ge1;
        emit[1] = s1_valid_reg && r_ge1 && at_last_col;
        emit[2] = s1_valid_reg && at_last_row && c_ge1;
        emit[3] = s1_valid_reg && at_last_row && at_last_col;

        is_last[0] = emit[0] && !emit[1] && !emit[2] && !emit[3];
        is_last[1] = emit[1] && !emit[2] && !emit[3];
        is_last[2] = emit[2] && !emit[3];
        is_last[3] = emit[3];

        item[0] = '{row: s1_row_reg - ROW_W'(1), column: s1_col_reg - COL_W'(1),
                    smoothed: nms_pkg::neighbour_mean(win0, r_ge2, 1'b1, c_ge2, 1'b1),
                    last: is_last[0]};
        item[1] = '{row: s1_row_reg - ROW_W'(1), column: s1_col_reg,
                    smoothed: nms_pkg::neighbour_mean(win1, r_ge2, 1'b1, 1'b1, 1'b0),
                    last: is_last[1]};
        item[2] = '{row: s1_row_reg, column: s1_col_reg - COL_W'(1),
                    smoothed: nms_pkg::neighbour_mean(win2, 1'b1, 1'b0, c_ge2, 1'b1),
                    last: is_last[2]};
        item[3] = '{row: s1_row_reg, column: s1_col_reg,
                    smoothed: nms_pkg::neighbour_mean(win3, 1'b1, 1'b0, 1'b1, 1'b0),
                    last: is_last[3]};

        // compact the emitted words into consecutive queue slots
        rank[0] = 3'd0;
        rank[1] = rank[0] + 3'(emit[0]);
        rank[2] = rank[1] + 3'(emit[1]);
        rank[3] = rank[2] + 3'(emit[2]);
        push_count = rank[3] + 3'(emit[3]);
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            win_l_reg <= win_m_reg;
            win_m_reg <= col_new;
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    nms_pkg::result_t outq_mem [nms_pkg::OUTQ_DEPTH];
    logic [PTR_W-1:0] outq_wr_reg, outq_wr_next;
    logic [PTR_W-1:0] outq_rd_reg, outq_rd_next;
    logic             out_accept;
    nms_pkg::result_t head;

    always_comb begin
        for (int k = 0; k < NRES; k++) begin
            wr_addr[k] = outq_wr_reg + PTR_W'(rank[k]);
        end
        out_accept      = m_valid && m_ready;
        outq_wr_next    = outq_wr_reg + PTR_W'(push_count);
        outq_rd_next    = outq_rd_reg + PTR_W'(out_accept);
        outq_count_next = outq_count_reg + CNT_W'(push_count) - CNT_W'(out_accept);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NRES; k++) begin
            if (emit[k]) begin
                outq_mem[wr_addr[k]] <= item[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outq_wr_reg    <= '0;
            outq_rd_reg    <= '0;
            outq_count_reg <= '0;
        end else begin
            outq_wr_reg    <= outq_wr_next;
            outq_rd_reg    <= outq_rd_next;
            outq_count_reg <= outq_count_next;
        end
    end

    assign head          = outq_mem[outq_rd_reg];
    assign m_valid       = (outq_count_reg != '0);
    assign m_out_row     = head.row;
    assign m_out_column  = head.column;
    assign m_smoothed    = head.smoothed;
    assign m_last_of_run = head.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // queue must always have room for what stage 1 pushes
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (CNT_W+1)'(outq_count_reg) + (CNT_W+1)'(push_count)
                         <= (CNT_W+1)'(nms_pkg::OUTQ_DEPTH))
        else $error("output queue overflow");

    // raster position stays inside the configured frame
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_position_reg <= last_row_reg) && (column_position_reg <= last_col_reg))
        else $error("raster position outside frame");

    // final sample of a frame yields four words
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && at_last_row && at_last_col) |-> (push_count == 3'd4))
        else $error("frame end did not emit four words");

    // words are only delivered from a non-empty queue; a pop with no stage-1 push lowers the count by one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg && out_accept |=> outq_count_reg == $past(outq_count_reg) - CNT_W'(1))
        else $error("queue count mismatch on pop");

endmodule
